// File: sv/rdnf_pkg.sv
package rdnf_pkg;

    localparam int POS_W = 13;

    localparam logic [POS_W-1:0] ROW_SIZE_RESET = 13'd4096;

    typedef enum logic
    {
        OP_DELETE = 1'b0,
        OP_CLEAR  = 1'b1
    } rdnf_op_t;

    typedef struct packed
    {
        logic             left_found;
        logic [POS_W-1:0] left_pos;
        logic             right_found;
        logic [POS_W-1:0] right_pos;
    } rdnf_result_t;

endpackage

// File: sv/rdnf_if.sv
interface rdnf_req_if
    import rdnf_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             opcode;
    logic [POS_W-1:0] first_pos;
    logic [POS_W-1:0] last_pos;

    modport source (output valid, output opcode, output first_pos, output last_pos, input ready);
    modport sink   (input valid, input opcode, input first_pos, input last_pos, output ready);
endinterface

interface rdnf_rsp_if
    import rdnf_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             left_found;
    logic [POS_W-1:0] left_pos;
    logic             right_found;
    logic [POS_W-1:0] right_pos;

    modport source (output valid, output left_found, output left_pos,
                    output right_found, output right_pos, input ready);
    modport sink   (input valid, input left_found, input left_pos,
                    input right_found, input right_pos, output ready);
endinterface

interface rdnf_cfg_if
    import rdnf_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [POS_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: sv/rdnf_result.sv
module rdnf_result
    import rdnf_pkg::*;
(
    input  logic [POS_W-1:0] lend,
    input  logic [POS_W-1:0] rend,
    input  logic [POS_W-1:0] row_size,
    input  logic             zero,
    output rdnf_result_t     result
);

    logic [POS_W-1:0] lft;
    logic [POS_W:0]   rgt;
    logic             lfound;
    logic             rfound;

    always_comb
    begin
        lft    = lend - POS_W'(1);
        lfound = (lend >= POS_W'(2)) && (lft <= row_size);
        rgt    = {1'b0, rend} + (POS_W+1)'(1);
        rfound = (rgt <= {1'b0, row_size});

        if (zero)
        begin
            result = '0;
        end
        else
        begin
            result.left_found  = lfound;
            result.left_pos    = lfound ? lft : '0;
            result.right_found = rfound;
            result.right_pos   = rgt[POS_W-1:0];
        end
    end

endmodule

// File: sv/range_delete_neighbor_finder_top.sv
// Range delete with nearest-survivor lookup.
//
// req carries one word per operation: opcode OP_DELETE kills positions
// first_pos..last_pos, OP_CLEAR empties the link store. rsp returns one word
// per operation: nearest alive position left and right of the merged dead
// block, each with a found flag. A clear returns an all-zero word.
// cfg writes row_size at any handshake; write it only while the block is idle.
//
// Timing: a delete's result word becomes valid in the same cycle that req.ready
// returns. The link store has one read and one write port, so the sequencer
// reads the neighbor links one at a time and writes the merged block ends one
// at a time. A clear sweeps the store one entry a cycle; its word and req.ready
// come once the sweep is done.
//
// Reset: row_size returns to 4096 and the store is swept to zero, which keeps
// req.ready low until the sweep ends. A stalled rsp holds its word; the block
// finishes the next operation and waits to hand over its result.
module range_delete_neighbor_finder_top
    import rdnf_pkg::*;
#(
    parameter int MAX_POSITIONS = 4096
)
(
    input  logic clk,
    input  logic rst_n,
    rdnf_req_if.sink   req,
    rdnf_rsp_if.source rsp,
    rdnf_cfg_if.sink   cfg
);

    localparam int AW = $clog2(MAX_POSITIONS);

    typedef enum logic [6:0]
    {
        S_IDLE  = 7'b0000001,
        S_RD1   = 7'b0000010,
        S_RD2   = 7'b0000100,
        S_WR1   = 7'b0001000,
        S_WR2   = 7'b0010000,
        S_DONE  = 7'b0100000,
        S_CLEAR = 7'b1000000
    } state_t;

    state_t           state_reg, state_next;
    logic [POS_W-1:0] row_size_reg;
    logic [POS_W-1:0] lo_reg, lo_next;
    logic [POS_W-1:0] hi_reg, hi_next;
    logic [POS_W-1:0] llink_reg, llink_next;
    logic [POS_W-1:0] lend_reg, lend_next;
    logic [POS_W-1:0] rend_reg, rend_next;
    logic             left_first_reg, left_first_next;
    logic             zero_reg, zero_next;
    logic             emit_reg, emit_next;
    logic [AW-1:0]    clr_cnt_reg, clr_cnt_next;
    logic             rd_ok_reg, rd_ok_next;
    logic             out_valid_reg, out_valid_next;
    rdnf_result_t     out_res_reg, out_res_next;

    logic [POS_W-1:0] mem [MAX_POSITIONS];
    logic [POS_W-1:0] rd_data_reg;
    logic [AW-1:0]    mem_ra;
    logic             mem_we;
    logic [AW-1:0]    mem_wa;
    logic [POS_W-1:0] mem_wd;

    logic             req_fire;
    logic [POS_W-1:0] link_rd;
    logic [POS_W:0]   lo_m1;
    logic [POS_W:0]   hi_p1;
    logic [POS_W-1:0] wr_pos;
    logic [POS_W-1:0] wr_val;
    rdnf_result_t     res;

    function automatic logic in_store(input logic [POS_W:0] p);
        return (p != '0) && (int'(p) <= MAX_POSITIONS);
    endfunction

    function automatic logic [AW-1:0] store_addr(input logic [POS_W:0] p);
        logic [POS_W:0] a;
        a = p - (POS_W+1)'(1);
        return AW'(a);
    endfunction

    assign req_fire  = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;

    assign rsp.valid       = out_valid_reg;
    assign rsp.left_found  = out_res_reg.left_found;
    assign rsp.left_pos    = out_res_reg.left_pos;
    assign rsp.right_found = out_res_reg.right_found;
    assign rsp.right_pos   = out_res_reg.right_pos;

    assign link_rd = rd_ok_reg ? rd_data_reg : '0;
    assign lo_m1   = {1'b0, req.first_pos} - (POS_W+1)'(1);
    assign hi_p1   = {1'b0, hi_reg} + (POS_W+1)'(1);

    rdnf_result u_result
    (
        .lend     (lend_reg),
        .rend     (rend_reg),
        .row_size (row_size_reg),
        .zero     (zero_reg),
        .result   (res)
    );

    always_comb
    begin
        state_next      = state_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        llink_next      = llink_reg;
        lend_next       = lend_reg;
        rend_next       = rend_reg;
        left_first_next = left_first_reg;
        zero_next       = zero_reg;
        emit_next       = emit_reg;
        clr_cnt_next    = clr_cnt_reg;
        rd_ok_next      = 1'b0;
        out_valid_next  = out_valid_reg;
        out_res_next    = out_res_reg;
        mem_ra          = '0;
        mem_we          = 1'b0;
        mem_wa          = '0;
        mem_wd          = '0;
        wr_pos          = '0;
        wr_val          = '0;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    if (req.opcode == OP_CLEAR)
                    begin
                        clr_cnt_next = '0;
                        zero_next    = 1'b1;
                        emit_next    = 1'b1;
                        state_next   = S_CLEAR;
                    end
                    else
                    begin
                        lo_next    = req.first_pos;
                        hi_next    = req.last_pos;
                        zero_next  = 1'b0;
                        // left neighbor link lives at first_pos - 1
                        mem_ra     = store_addr(lo_m1);
                        rd_ok_next = (req.first_pos > POS_W'(1)) && in_store(lo_m1);
                        state_next = S_RD1;
                    end
                end
            end
            S_RD1:
            begin
                llink_next = link_rd;
                mem_ra     = store_addr(hi_p1);
                rd_ok_next = (hi_reg != row_size_reg) && in_store(hi_p1);
                state_next = S_RD2;
            end
            S_RD2:
            begin
                left_first_next = (llink_reg != '0);
                lend_next       = (llink_reg != '0) ? llink_reg : lo_reg;
                rend_next       = (link_rd != '0) ? link_rd : hi_reg;
                state_next      = S_WR1;
            end
            S_WR1:
            begin
                wr_pos     = left_first_reg ? lend_reg : rend_reg;
                wr_val     = left_first_reg ? rend_reg : lend_reg;
                mem_we     = in_store({1'b0, wr_pos});
                mem_wa     = store_addr({1'b0, wr_pos});
                mem_wd     = wr_val;
                state_next = S_WR2;
            end
            S_WR2:
            begin
                wr_pos     = left_first_reg ? rend_reg : lend_reg;
                wr_val     = left_first_reg ? lend_reg : rend_reg;
                mem_we     = in_store({1'b0, wr_pos});
                mem_wa     = store_addr({1'b0, wr_pos});
                mem_wd     = wr_val;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // hold until the output word is free
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_res_next   = res;
                    state_next     = S_IDLE;
                end
            end
            S_CLEAR:
            begin
                mem_we       = 1'b1;
                mem_wa       = clr_cnt_reg;
                mem_wd       = '0;
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == AW'(MAX_POSITIONS - 1))
                begin
                    clr_cnt_next = '0;
                    state_next   = emit_reg ? S_DONE : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= mem[mem_ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            row_size_reg  <= ROW_SIZE_RESET;
            clr_cnt_reg   <= '0;
            emit_reg      <= 1'b0;
            zero_reg      <= 1'b0;
            rd_ok_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            emit_reg      <= emit_next;
            zero_reg      <= zero_next;
            rd_ok_reg     <= rd_ok_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid && cfg.ready)
            begin
                row_size_reg <= cfg.data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        llink_reg      <= llink_next;
        lend_reg       <= lend_next;
        rend_reg       <= rend_next;
        left_first_reg <= left_first_next;
        out_res_reg    <= out_res_next;
    end

    a_rsp_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp.valid) |-> $past(state_reg == S_DONE))
        else $error("result word appeared outside the done step");

    a_clear_sweeps: assert property (@(posedge clk) disable iff (!rst_n)
        (req_fire && req.opcode == OP_CLEAR) |=> (state_reg == S_CLEAR && clr_cnt_reg == '0))
        else $error("clear did not start a store sweep");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == S_WR1 || state_reg == S_WR2 || state_reg == S_CLEAR))
        else $error("link store written outside a write step");

    a_found_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.left_found || rsp.right_found)) |->
            ((!rsp.left_found || rsp.left_pos != '0) &&
             (!rsp.right_found || rsp.right_pos != '0)))
        else $error("found flag with zero position");

endmodule
